// ===== rtl/core/crc_checked_command_frame_parser_core_assert.svh =====
// Assertion macros for the command frame parser core.
// Taken in by the top level; needs no other file.
`ifndef CRC_CHECKED_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH
`define CRC_CHECKED_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CCFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame parser check failed");
`define CCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame parser check failed");
`else
`define CCFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/ccfp_pkg.sv =====
// Package for the command frame parser: phase and status codes, framing
// characters, the result record and the byte-wide CRC-16 update. No dependencies.
`timescale 1ns / 1ps

package ccfp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CMD    = 3'd1,
        PH_SEP    = 3'd2,
        PH_ARG    = 3'd3,
        PH_CHK_LO = 3'd4,
        PH_CHK_HI = 3'd5
    } t_phase;

    typedef enum logic [3:0] {
        ST_NOISE   = 4'd0,
        ST_START   = 4'd1,
        ST_CMD     = 4'd2,
        ST_ARG     = 4'd3,
        ST_SEP     = 4'd4,
        ST_CRC_LO  = 4'd5,
        ST_OK      = 4'd6,
        ST_BAD     = 4'd7,
        ST_CMD_OVF = 4'd8,
        ST_BAD_SEP = 4'd9,
        ST_ARG_OVF = 4'd10
    } t_status;

    localparam logic [7:0]  CHAR_START = 8'h21;
    localparam logic [7:0]  CHAR_ARG   = 8'h2B;
    localparam logic [7:0]  CHAR_END   = 8'h2A;
    localparam logic [7:0]  CHAR_NUL   = 8'h00;
    localparam logic [15:0] CRC_INIT   = 16'h0001;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    typedef struct packed {
        t_status     status;
        logic [7:0]  data_byte;
        logic [2:0]  field_index;
        logic [3:0]  position;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } t_result;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/ccfp_frame_fsm.sv =====
// Frame parser state machine: phase, field counters, running CRC and checksum.
// Uses ccfp_pkg for codes, the result record and the CRC update.
`timescale 1ns / 1ps

module ccfp_frame_fsm #(
    parameter int FIELD_LEN = 16,
    parameter int MAX_ARGS  = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output ccfp_pkg::t_result o_result
);

    localparam int BW = $clog2(FIELD_LEN + 1);
    localparam int AW = $clog2(MAX_ARGS + 1);
    localparam int FW = ((AW > 3) ? AW : 3) + 1;
    localparam int PW = (BW > 4) ? BW : 4;

    ccfp_pkg::t_phase r_phase, n_phase;
    logic [BW-1:0]    r_byte_cnt, n_byte_cnt;
    logic [AW-1:0]    r_arg_cnt, n_arg_cnt;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_chk_lo, n_chk_lo;

    logic [FW-1:0] w_arg_ext;
    logic [FW-1:0] w_arg_inc;
    logic [PW-1:0] w_pos_ext;
    logic [15:0]   w_crc_fed;
    logic [15:0]   w_rcv;

    assign w_arg_ext = FW'(r_arg_cnt);
    assign w_arg_inc = w_arg_ext + FW'(1);
    assign w_pos_ext = PW'(r_byte_cnt);
    assign w_crc_fed = ccfp_pkg::crc16_feed(r_crc, i_byte);
    assign w_rcv     = {i_byte, r_chk_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ccfp_pkg::PH_IDLE;
            r_byte_cnt <= '0;
            r_arg_cnt  <= '0;
            r_crc      <= ccfp_pkg::CRC_INIT;
            r_chk_lo   <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_byte_cnt <= n_byte_cnt;
            r_arg_cnt  <= n_arg_cnt;
            r_crc      <= n_crc;
            r_chk_lo   <= n_chk_lo;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_byte_cnt = r_byte_cnt;
        n_arg_cnt  = r_arg_cnt;
        n_crc      = r_crc;
        n_chk_lo   = r_chk_lo;

        o_result.status       = ccfp_pkg::ST_NOISE;
        o_result.data_byte    = i_byte;
        o_result.field_index  = 3'd0;
        o_result.position     = 4'd0;
        o_result.received_crc = 16'd0;

        unique case (r_phase)
            ccfp_pkg::PH_IDLE: begin
                if (i_byte == ccfp_pkg::CHAR_START) begin
                    o_result.status = ccfp_pkg::ST_START;
                    n_phase    = ccfp_pkg::PH_CMD;
                    n_byte_cnt = '0;
                    n_arg_cnt  = '0;
                    n_crc      = ccfp_pkg::CRC_INIT;
                end
            end
            ccfp_pkg::PH_CMD: begin
                o_result.position = w_pos_ext[3:0];
                if (r_byte_cnt >= BW'(FIELD_LEN)) begin
                    o_result.status = ccfp_pkg::ST_CMD_OVF;
                    n_phase = ccfp_pkg::PH_IDLE;
                end else begin
                    o_result.status = ccfp_pkg::ST_CMD;
                    n_crc      = w_crc_fed;
                    n_byte_cnt = r_byte_cnt + BW'(1);
                    if (i_byte == ccfp_pkg::CHAR_NUL) begin
                        n_phase = ccfp_pkg::PH_SEP;
                    end
                end
            end
            ccfp_pkg::PH_SEP: begin
                o_result.field_index = w_arg_ext[2:0];
                n_crc = w_crc_fed;
                if (i_byte == ccfp_pkg::CHAR_ARG) begin
                    o_result.status = ccfp_pkg::ST_SEP;
                    n_phase    = ccfp_pkg::PH_ARG;
                    n_byte_cnt = '0;
                end else if (i_byte == ccfp_pkg::CHAR_END) begin
                    o_result.status = ccfp_pkg::ST_SEP;
                    n_phase    = ccfp_pkg::PH_CHK_LO;
                    n_byte_cnt = '0;
                end else begin
                    o_result.status = ccfp_pkg::ST_BAD_SEP;
                    n_phase = ccfp_pkg::PH_IDLE;
                end
            end
            ccfp_pkg::PH_ARG: begin
                o_result.position = w_pos_ext[3:0];
                if (r_arg_cnt >= AW'(MAX_ARGS) || r_byte_cnt >= BW'(FIELD_LEN)) begin
                    o_result.status      = ccfp_pkg::ST_ARG_OVF;
                    o_result.field_index = w_arg_ext[2:0];
                    n_phase = ccfp_pkg::PH_IDLE;
                end else begin
                    o_result.status      = ccfp_pkg::ST_ARG;
                    o_result.field_index = w_arg_inc[2:0];
                    n_crc      = w_crc_fed;
                    n_byte_cnt = r_byte_cnt + BW'(1);
                    if (i_byte == ccfp_pkg::CHAR_NUL) begin
                        n_phase   = ccfp_pkg::PH_SEP;
                        n_arg_cnt = r_arg_cnt + AW'(1);
                    end
                end
            end
            ccfp_pkg::PH_CHK_LO: begin
                o_result.status      = ccfp_pkg::ST_CRC_LO;
                o_result.field_index = w_arg_ext[2:0];
                n_chk_lo = i_byte;
                n_phase  = ccfp_pkg::PH_CHK_HI;
            end
            ccfp_pkg::PH_CHK_HI: begin
                o_result.field_index  = w_arg_ext[2:0];
                o_result.received_crc = w_rcv;
                o_result.status = (w_rcv == r_crc) ? ccfp_pkg::ST_OK : ccfp_pkg::ST_BAD;
                n_phase = ccfp_pkg::PH_IDLE;
            end
            default: begin
                n_phase = ccfp_pkg::PH_IDLE;
            end
        endcase

        o_result.computed_crc = n_crc;
    end

endmodule

// ===== rtl/core/crc_checked_command_frame_parser_core.sv =====
// Top level of the CRC-checked command frame parser: input register, parser
// state machine (ccfp_frame_fsm) and result register. Uses ccfp_pkg.
//
//   Channel   Direction  Handshake                   Payload
//   rx        in         i_rx_valid / o_rx_stall     i_rx_byte
//   res       out        o_res_valid / i_res_stall   o_status, o_data_byte, o_field_index,
//                                                    o_position, o_computed_crc,
//                                                    o_received_crc
//
// One byte per cycle while the result side does not stall; each byte goes from the input register,
// through the CRC-16 byte update and the phase decision, into the result register.
// Reset is synchronous and active low and returns the parser to idle with the CRC at one.
// A stall on a valid result holds the result register and a full input register, and
// stalls the input side only when both are full.
`timescale 1ns / 1ps

`include "crc_checked_command_frame_parser_core_assert.svh"

module crc_checked_command_frame_parser_core #(
    parameter int FIELD_LEN = 16,
    parameter int MAX_ARGS  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [3:0]  o_status,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_field_index,
    output logic [3:0]  o_position,
    output logic [15:0] o_computed_crc,
    output logic [15:0] o_received_crc
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    ccfp_pkg::t_result r_out;
    ccfp_pkg::t_result w_result;
    logic              w_advance;
    logic              w_step;
    logic              w_in_load;
    logic              w_res_ok;
    logic              w_res_mid;
    logic              w_full;

    assign w_advance = !r_out_valid || !i_res_stall;
    assign w_step    = r_in_valid && w_advance;
    assign w_in_load = !r_in_valid || w_advance;
    assign o_rx_stall = !w_in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    ccfp_frame_fsm #(
        .FIELD_LEN(FIELD_LEN),
        .MAX_ARGS (MAX_ARGS)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_result(w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_data_byte    = r_out.data_byte;
    assign o_field_index  = r_out.field_index;
    assign o_position     = r_out.position;
    assign o_computed_crc = r_out.computed_crc;
    assign o_received_crc = r_out.received_crc;

    assign w_res_ok  = o_res_valid && (o_status == ccfp_pkg::ST_OK);
    assign w_res_mid = o_res_valid && (o_status != ccfp_pkg::ST_OK)
                       && (o_status != ccfp_pkg::ST_BAD);
    assign w_full    = r_in_valid && r_out_valid;

    `CCFP_ASSERT_IMPLIES(a_ok_means_match, i_clk, i_rst_n, w_res_ok, o_computed_crc == o_received_crc)
    `CCFP_ASSERT_IMPLIES(a_rcv_only_at_end, i_clk, i_rst_n, w_res_mid, o_received_crc == 16'd0)
    `CCFP_ASSERT_IMPLIES(a_stall_only_full, i_clk, i_rst_n, o_rx_stall, w_full && i_res_stall)
    `CCFP_ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, w_step, r_out_valid)

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the CRC-checked command frame parser core. It sends directed and random
// frames, predicts the result of every byte and checks each one field by field.
// Depends on ccfp_pkg and on crc_checked_command_frame_parser_core.

module tb;

    localparam int FIELD_LEN    = 16;
    localparam int MAX_ARGS     = 4;
    localparam int RANDOM_BYTES = 900;
    localparam int GAP_PERCENT  = 34;

    class frame_scoreboard;
        int                 field_len;
        int                 max_args;
        ccfp_pkg::t_phase   phase;
        logic [4:0]         held;
        logic [2:0]         args_done;
        logic [15:0]        crc;
        logic [7:0]         chk_lo;
        ccfp_pkg::t_result  expected_q[$];
        int                 fails;

        function new(int field_len_i, int max_args_i);
            field_len = field_len_i;
            max_args  = max_args_i;
            phase     = ccfp_pkg::PH_IDLE;
            held      = '0;
            args_done = '0;
            crc       = ccfp_pkg::CRC_INIT;
            chk_lo    = '0;
            fails     = 0;
        endfunction

        static function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? ccfp_pkg::CRC_POLY : 16'h0000);
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            ccfp_pkg::t_result r;
            r           = '0;
            r.status    = ccfp_pkg::ST_NOISE;
            r.data_byte = b;
            case (phase)
                ccfp_pkg::PH_IDLE: begin
                    if (b == ccfp_pkg::CHAR_START) begin
                        r.status  = ccfp_pkg::ST_START;
                        phase     = ccfp_pkg::PH_CMD;
                        held      = '0;
                        args_done = '0;
                        crc       = ccfp_pkg::CRC_INIT;
                    end
                end
                ccfp_pkg::PH_CMD: begin
                    r.position = held[3:0];
                    if (held >= field_len) begin
                        r.status = ccfp_pkg::ST_CMD_OVF;
                        phase    = ccfp_pkg::PH_IDLE;
                    end else begin
                        r.status = ccfp_pkg::ST_CMD;
                        crc      = crc_update(crc, b);
                        held++;
                        if (b == ccfp_pkg::CHAR_NUL) phase = ccfp_pkg::PH_SEP;
                    end
                end
                ccfp_pkg::PH_SEP: begin
                    r.field_index = args_done;
                    crc           = crc_update(crc, b);
                    if (b == ccfp_pkg::CHAR_ARG) begin
                        r.status = ccfp_pkg::ST_SEP;
                        phase    = ccfp_pkg::PH_ARG;
                        held     = '0;
                    end else if (b == ccfp_pkg::CHAR_END) begin
                        r.status = ccfp_pkg::ST_SEP;
                        phase    = ccfp_pkg::PH_CHK_LO;
                        held     = '0;
                    end else begin
                        r.status = ccfp_pkg::ST_BAD_SEP;
                        phase    = ccfp_pkg::PH_IDLE;
                    end
                end
                ccfp_pkg::PH_ARG: begin
                    r.position = held[3:0];
                    if (args_done >= max_args || held >= field_len) begin
                        r.status      = ccfp_pkg::ST_ARG_OVF;
                        r.field_index = args_done;
                        phase         = ccfp_pkg::PH_IDLE;
                    end else begin
                        r.status      = ccfp_pkg::ST_ARG;
                        r.field_index = args_done + 3'd1;
                        crc           = crc_update(crc, b);
                        held++;
                        if (b == ccfp_pkg::CHAR_NUL) begin
                            phase = ccfp_pkg::PH_SEP;
                            args_done++;
                        end
                    end
                end
                ccfp_pkg::PH_CHK_LO: begin
                    r.status      = ccfp_pkg::ST_CRC_LO;
                    r.field_index = args_done;
                    chk_lo        = b;
                    phase         = ccfp_pkg::PH_CHK_HI;
                end
                ccfp_pkg::PH_CHK_HI: begin
                    r.field_index  = args_done;
                    r.received_crc = {b, chk_lo};
                    r.status       = (r.received_crc == crc) ? ccfp_pkg::ST_OK
                                                             : ccfp_pkg::ST_BAD;
                    phase          = ccfp_pkg::PH_IDLE;
                end
                default: begin
                    phase = ccfp_pkg::PH_IDLE;
                end
            endcase
            r.computed_crc = crc;
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(ccfp_pkg::t_result got);
            ccfp_pkg::t_result want;
            if (expected_q.size() == 0) begin
                $error("result with no byte pending: status %0d, byte %0h",
                       got.status, got.data_byte);
                fails++;
                return;
            end
            want = expected_q.pop_front();
            check_field("status", 16'(want.status), 16'(got.status));
            check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
            check_field("field_index", 16'(want.field_index), 16'(got.field_index));
            check_field("position", 16'(want.position), 16'(got.position));
            check_field("computed_crc", want.computed_crc, got.computed_crc);
            check_field("received_crc", want.received_crc, got.received_crc);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_res_valid;
    logic        i_res_stall = 1'b0;
    logic [3:0]  o_status;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_field_index;
    logic [3:0]  o_position;
    logic [15:0] o_computed_crc;
    logic [15:0] o_received_crc;

    logic [7:0]      line_bytes[$];
    frame_scoreboard sb;
    int              results_seen = 0;

    always #1 i_clk = ~i_clk;

    crc_checked_command_frame_parser_core #(
        .FIELD_LEN(FIELD_LEN),
        .MAX_ARGS (MAX_ARGS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .i_rx_byte     (i_rx_byte),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_status      (o_status),
        .o_data_byte   (o_data_byte),
        .o_field_index (o_field_index),
        .o_position    (o_position),
        .o_computed_crc(o_computed_crc),
        .o_received_crc(o_received_crc)
    );

    task automatic put(input logic [7:0] b, inout logic [15:0] crc);
        line_bytes.push_back(b);
        crc = frame_scoreboard::crc_update(crc, b);
    endtask

    task automatic add_field(input int len, inout logic [15:0] crc);
        repeat (len) put(8'($urandom_range(1, 255)), crc);
        put(ccfp_pkg::CHAR_NUL, crc);
    endtask

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, FIELD_LEN - 1);
        end
        return $urandom_range(0, 4);
    endfunction

    task automatic add_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom_range(0, 255));
            if (b == ccfp_pkg::CHAR_START && $urandom_range(0, 3) != 0) begin
                b = ccfp_pkg::CHAR_NUL;
            end
            line_bytes.push_back(b);
        end
    endtask

    // Kinds below 34 break the frame: command overflow, argument overflow,
    // bad separator, then a corrupted checksum. The rest are well formed.
    task automatic add_frame(input int kind);
        logic [15:0] crc;
        int          n_args;
        logic [7:0]  b;
        crc = ccfp_pkg::CRC_INIT;
        line_bytes.push_back(ccfp_pkg::CHAR_START);
        if (kind < 8) begin
            repeat (FIELD_LEN) put(8'($urandom_range(1, 255)), crc);
            line_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        add_field(pick_len(), crc);
        n_args = $urandom_range(0, MAX_ARGS);
        repeat (n_args) begin
            put(ccfp_pkg::CHAR_ARG, crc);
            add_field(pick_len(), crc);
        end
        if (kind < 16) begin
            put(ccfp_pkg::CHAR_ARG, crc);
            if (n_args < MAX_ARGS) begin
                repeat (FIELD_LEN) put(8'($urandom_range(1, 255)), crc);
            end
            line_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (kind < 24) begin
            b = 8'($urandom_range(0, 255));
            if (b == ccfp_pkg::CHAR_ARG || b == ccfp_pkg::CHAR_END) b = 8'hC3;
            line_bytes.push_back(b);
            return;
        end
        put(ccfp_pkg::CHAR_END, crc);
        if (kind < 34) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        line_bytes.push_back(crc[7:0]);
        line_bytes.push_back(crc[15:8]);
    endtask

    task automatic build_directed();
        logic [15:0] crc;
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(ccfp_pkg::CHAR_NUL);
        crc = ccfp_pkg::CRC_INIT;
        line_bytes.push_back(ccfp_pkg::CHAR_START);
        put(ccfp_pkg::CHAR_START, crc);
        put(8'hFF, crc);
        put(ccfp_pkg::CHAR_NUL, crc);
        put(ccfp_pkg::CHAR_ARG, crc);
        put(8'h01, crc);
        put(ccfp_pkg::CHAR_NUL, crc);
        put(ccfp_pkg::CHAR_END, crc);
        line_bytes.push_back(crc[7:0]);
        line_bytes.push_back(crc[15:8]);
        line_bytes.push_back(ccfp_pkg::CHAR_START);
        line_bytes.push_back(ccfp_pkg::CHAR_NUL);
        line_bytes.push_back(8'h80);
        crc = ccfp_pkg::CRC_INIT;
        line_bytes.push_back(ccfp_pkg::CHAR_START);
        put(ccfp_pkg::CHAR_NUL, crc);
        put(ccfp_pkg::CHAR_END, crc);
        line_bytes.push_back(~crc[7:0]);
        line_bytes.push_back(crc[15:8]);
    endtask

    task automatic send_bytes();
        for (int k = 0; k < line_bytes.size(); k++) begin
            if (k < 400 || k >= 600) begin
                while ($urandom_range(0, 99) < GAP_PERCENT) begin
                    i_rx_valid <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_rx_valid <= 1'b1;
            i_rx_byte  <= line_bytes[k];
            @(posedge i_clk);
            while (o_rx_stall) @(posedge i_clk);
            sb.note_byte(line_bytes[k]);
        end
        i_rx_valid <= 1'b0;
    endtask

    initial begin
        ccfp_pkg::t_result got;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_res_valid === 1'b1 && i_res_stall === 1'b0) begin
                got.status       = ccfp_pkg::t_status'(o_status);
                got.data_byte    = o_data_byte;
                got.field_index  = o_field_index;
                got.position     = o_position;
                got.computed_crc = o_computed_crc;
                got.received_crc = o_received_crc;
                sb.check_result(got);
                results_seen++;
            end
            if (results_seen >= 400 && results_seen < 600) begin
                i_res_stall <= 1'b0;
            end else begin
                i_res_stall <= ($urandom_range(0, 99) < GAP_PERCENT);
            end
        end
    end

    initial begin
        int directed_len;
        sb = new(FIELD_LEN, MAX_ARGS);
        build_directed();
        directed_len = line_bytes.size();
        add_frame(0);
        add_frame(12);
        while (line_bytes.size() < directed_len + RANDOM_BYTES) begin
            if ($urandom_range(0, 99) < 15) add_noise();
            add_frame($urandom_range(0, 99));
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_bytes();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
